[hdl/free_list_slot_allocator_unit_macros.svh]
// assertion macros for the checker of the slot allocator
`ifndef FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// property must hold at every edge outside reset
`define FSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define FSA_NEVER(label, clk, rst_n, cond, msg) \
    `FSA_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[hdl/fsa_pkg.sv]
`timescale 1ns / 1ps
package fsa_pkg;

    localparam int unsigned SLOT_W      = 10;
    localparam int unsigned ID_IN_W     = 10;
    localparam int unsigned ID_SPACE    = 1 << ID_IN_W;
    // reciprocal scaling for the id reduction, 1 << 20
    localparam int unsigned RECIP_SHIFT = 20;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NO_FRESH = 2'd1;
    localparam t_status ST_UNMAPPED = 2'd2;
    localparam t_status ST_DROPPED  = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic ORDER_FIFO = 1'b0;
    localparam logic ORDER_LIFO = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_id_entry;

    // requests from the control sequencer to the pool
    typedef struct packed {
        logic rd;
        logic lifo;
        logic pop;
        logic push;
    } t_pool_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_pool_sts;

endpackage

[hdl/fsa_pool.sv]
`timescale 1ns / 1ps
module fsa_pool #(
    parameter int unsigned POOL_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fsa_pkg::t_pool_ctl            i_ctl,
    input  logic [fsa_pkg::SLOT_W-1:0]    i_push_data,
    output logic [fsa_pkg::SLOT_W-1:0]    o_rd_data,
    output fsa_pkg::t_pool_sts            o_sts
);
    import fsa_pkg::*;

    localparam int unsigned PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned FW = $clog2(POOL_DEPTH + 1);

    logic [SLOT_W-1:0] r_mem [POOL_DEPTH];
    logic [SLOT_W-1:0] r_rd_data;
    logic [PW-1:0]     r_head;
    logic [PW-1:0]     r_tail;
    logic [FW-1:0]     r_fill;
    logic [PW-1:0]     n_head;
    logic [PW-1:0]     n_tail;
    logic [FW-1:0]     n_fill;
    logic [PW-1:0]     w_head_next;
    logic [PW-1:0]     w_tail_next;
    logic [PW-1:0]     w_tail_prev;
    logic [PW-1:0]     w_rd_addr;

    assign w_head_next = (r_head == PW'(POOL_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_next = (r_tail == PW'(POOL_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign w_tail_prev = (r_tail == '0) ? PW'(POOL_DEPTH - 1) : r_tail - 1'b1;

    // oldest entry sits at head, newest one below tail
    assign w_rd_addr = i_ctl.lifo ? w_tail_prev : r_head;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.pop) begin
            if (i_ctl.lifo) begin
                n_tail = w_tail_prev;
            end else begin
                n_head = w_head_next;
            end
            n_fill = r_fill - 1'b1;
        end else if (i_ctl.push) begin
            n_tail = w_tail_next;
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !i_ctl.pop) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    assign o_rd_data   = r_rd_data;
    assign o_sts.empty = (r_fill == '0);
    assign o_sts.full  = (r_fill == FW'(POOL_DEPTH));

endmodule

[hdl/free_list_slot_allocator_unit.sv]
// per item: accept, table/pool read, then read-modify-write commit into the output register
// the sequencer stalls the input outside idle, so one item is in flight at a time;
// a stalled result beat holds the next item in its commit step
// reset (sync, active low): pointers, counters and order clear, then the id table is
// swept to unmapped entry by entry (ID_DEPTH entries, at most 1024) with input stalled
`timescale 1ns / 1ps
module free_list_slot_allocator_unit #(
    parameter int unsigned POOL_DEPTH = 1024,
    parameter int unsigned ID_COUNT   = 1024,
    parameter int unsigned SLOT_COUNT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_wdata,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [fsa_pkg::ID_IN_W-1:0]    i_obj_id,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fsa_pkg::SLOT_W-1:0]     o_slot_handle,
    output logic                           o_from_pool,
    output fsa_pkg::t_status               o_status
);
    import fsa_pkg::*;

    // ids above the table fold back modulo ID_COUNT, so only this many entries exist
    localparam int unsigned ID_DEPTH = (ID_COUNT < ID_SPACE) ? ID_COUNT : ID_SPACE;
    localparam int unsigned ID_AW    = $clog2(ID_DEPTH);
    localparam int unsigned FRESH_W  = $clog2(SLOT_COUNT + 1);
    // floor(2^20 / ID_COUNT); the quotient estimate is exact or one low
    localparam int unsigned RECIP    = (32'd1 << RECIP_SHIFT) / ID_COUNT;
    localparam int unsigned PROD_W   = ID_IN_W + RECIP_SHIFT + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_UPD   = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [ID_AW-1:0]   r_clr_idx;
    logic               r_pool_order;

    // captured item
    logic               r_func;
    logic [ID_IN_W-1:0] r_obj_id;
    logic [ID_IN_W-1:0] r_quot;
    logic [ID_AW-1:0]   r_id;

    // id table: slot plus mapped flag in one word
    t_id_entry          r_id_mem [ID_DEPTH];
    t_id_entry          r_id_rd;

    logic [FRESH_W-1:0] r_next_fresh;

    // output register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_from_pool;
    t_status            r_status;

    logic                      w_accept;
    logic                      w_commit;
    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-1:0]         w_qd;
    logic [PROD_W-1:0]         w_rem;
    logic [PROD_W-1:0]         w_rem_fix;
    logic [ID_AW-1:0]          w_id;
    logic [FRESH_W+SLOT_W-1:0] w_fresh_ext;
    logic [SLOT_W-1:0]         w_fresh_slot;
    logic                      w_fresh_ok;

    // combinational result of the commit step
    logic [SLOT_W-1:0]  w_slot;
    logic               w_from_pool;
    t_status            w_status;
    logic               w_fresh_take;
    logic               w_tbl_we;
    t_id_entry          w_tbl_wdata;
    logic               w_id_we;
    logic [ID_AW-1:0]   w_id_waddr;
    t_id_entry          w_id_wdata;

    t_pool_ctl          w_pool_ctl;
    t_pool_sts          w_pool_sts;
    logic [SLOT_W-1:0]  w_pool_rd;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    // commit only when the output register is free or draining this cycle
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);

    // id reduction, stage one: quotient estimate registered at accept
    assign w_prod = PROD_W'(i_obj_id) * PROD_W'(RECIP);

    // stage two: remainder with a single correction
    assign w_qd      = PROD_W'(r_quot) * PROD_W'(ID_COUNT);
    assign w_rem     = PROD_W'(r_obj_id) - w_qd;
    assign w_rem_fix = (w_rem >= PROD_W'(ID_COUNT)) ? w_rem - PROD_W'(ID_COUNT) : w_rem;
    assign w_id      = w_rem_fix[ID_AW-1:0];

    // fresh slot numbers are reported in the low handle bits
    assign w_fresh_ext  = {{SLOT_W{1'b0}}, r_next_fresh};
    assign w_fresh_slot = w_fresh_ext[SLOT_W-1:0];
    assign w_fresh_ok   = (r_next_fresh < FRESH_W'(SLOT_COUNT));

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == ID_AW'(ID_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // read-modify-write of table and pool for the item in flight
    always_comb begin
        w_slot       = '0;
        w_from_pool  = 1'b0;
        w_status     = ST_OK;
        w_fresh_take = 1'b0;
        w_tbl_we     = 1'b0;
        w_tbl_wdata  = '0;
        w_pool_ctl   = '0;
        w_pool_ctl.rd   = (r_state == S_LOOK);
        w_pool_ctl.lifo = (r_pool_order == ORDER_LIFO);
        if (r_func == FUNC_ALLOC) begin
            if (!w_pool_sts.empty) begin
                w_slot         = w_pool_rd;
                w_from_pool    = 1'b1;
                w_pool_ctl.pop = w_commit;
            end else if (w_fresh_ok) begin
                w_slot       = w_fresh_slot;
                w_fresh_take = w_commit;
            end else begin
                w_status = ST_NO_FRESH;
            end
            // remap replaces any older mapping of the id
            if (w_status == ST_OK) begin
                w_tbl_we          = w_commit;
                w_tbl_wdata.valid = 1'b1;
                w_tbl_wdata.slot  = w_slot;
            end
        end else begin
            if (!r_id_rd.valid) begin
                w_status = ST_UNMAPPED;
            end else begin
                w_slot            = r_id_rd.slot;
                w_tbl_we          = w_commit;
                w_tbl_wdata.valid = 1'b0;
                w_tbl_wdata.slot  = r_id_rd.slot;
                if (w_pool_sts.full) begin
                    w_status = ST_DROPPED;
                end else begin
                    w_pool_ctl.push = w_commit;
                end
            end
        end
    end

    // one write port on the id table: clearing sweep or commit
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_id_we    = 1'b1;
            w_id_waddr = r_clr_idx;
            w_id_wdata = '0;
        end else begin
            w_id_we    = w_tbl_we;
            w_id_waddr = r_id;
            w_id_wdata = w_tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_id_we) begin
            r_id_mem[w_id_waddr] <= w_id_wdata;
        end
        if (r_state == S_LOOK) begin
            r_id_rd <= r_id_mem[w_id];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_pool_order <= ORDER_FIFO;
            r_next_fresh <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cfg_we) begin
                r_pool_order <= i_cfg_wdata;
            end
            if (w_fresh_take) begin
                r_next_fresh <= r_next_fresh + 1'b1;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func   <= i_func;
            r_obj_id <= i_obj_id;
            r_quot   <= w_prod[RECIP_SHIFT +: ID_IN_W];
        end
        if (r_state == S_LOOK) begin
            r_id <= w_id;
        end
        if (w_commit) begin
            r_slot      <= w_slot;
            r_from_pool <= w_from_pool;
            r_status    <= w_status;
        end
    end

    fsa_pool #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_pool_ctl),
        .i_push_data (w_slot),
        .o_rd_data   (w_pool_rd),
        .o_sts       (w_pool_sts)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_slot_handle = r_slot;
    assign o_from_pool   = r_from_pool;
    assign o_status      = r_status;

endmodule

[hdl/fsa_chk.sv]
`timescale 1ns / 1ps
`include "free_list_slot_allocator_unit_macros.svh"
module fsa_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [fsa_pkg::SLOT_W-1:0]     o_slot_handle,
    input  logic                           o_from_pool,
    input  fsa_pkg::t_status               o_status
);
    import fsa_pkg::*;

    // a stalled result beat holds its payload
    `FSA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot_handle) && $stable(o_from_pool) && $stable(o_status), "stalled result beat changed")

    // one item in flight: an accepted beat is followed by a stalled input
    `FSA_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input accepted back to back")

    // a reused slot only comes with a good status
    `FSA_NEVER(a_pool_ok, i_clk, i_rst_n, o_out_valid && o_from_pool && o_status != ST_OK, "reused slot with error status")

    // failed alloc or unmapped free carries a zero handle
    `FSA_NEVER(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_NO_FRESH || o_status == ST_UNMAPPED) && (o_slot_handle != '0 || o_from_pool), "error result with nonzero handle")

endmodule

bind free_list_slot_allocator_unit fsa_chk u_fsa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_slot_handle (o_slot_handle),
    .o_from_pool   (o_from_pool),
    .o_status      (o_status)
);
